>>> hw/rtl/wes_pkg.sv
// Shared types, constants and helper functions for the window edge snap block.
// No dependencies; every other file refers to this package by scoped names.
package wes_pkg;

  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 15;

  localparam logic [7:0]  SNAP_DISTANCE_RESET = 8'd12;
  localparam logic [14:0] SCREEN_WIDTH_RESET  = 15'd1024;
  localparam logic [14:0] SCREEN_HEIGHT_RESET = 15'd768;
  localparam logic [7:0]  TITLE_HEIGHT_RESET  = 8'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SNAP_DISTANCE = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2,
    CFG_TITLE_HEIGHT  = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_START    = 1'b0,
    OP_NEIGHBOR = 1'b1
  } op_t;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    logic [7:0]  snap_distance;
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [7:0]  title_height;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    coord_t      pos_x;
    coord_t      pos_y;
    logic [14:0] win_width;
    logic [14:0] win_height;
    logic        titled;
    logic [6:0]  border_width;
    logic        last;
  } in_item_t;

  // Classified work item passed from front to back.
  // start:    px/py first-pass snapped, aux = far screen edge offsets
  // neighbor: px/py rectangle origin (title grown), aux = right / bottom edge
  typedef struct packed {
    logic       nbr;
    logic       last;
    coord_t     px;
    coord_t     py;
    coord_t     len_x;
    coord_t     len_y;
    coord_t     aux_x;
    coord_t     aux_y;
    logic [7:0] tofs;
  } job_t;

  function automatic logic [16:0] mag(coord_t v);
    return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic below_sd(coord_t v, logic [7:0] sd);
    return mag(v) < {9'd0, sd};
  endfunction

  // signed v <= unsigned sd
  function automatic logic le_sd(coord_t v, logic [7:0] sd);
    return v[15] || (v[14:0] <= {7'd0, sd});
  endfunction

  // smaller magnitude; a tie goes to b
  function automatic coord_t lastmin(coord_t a, coord_t b);
    return (mag(a) < mag(b)) ? a : b;
  endfunction

endpackage

>>> hw/rtl/wes_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on wes_pkg for the coordinate type.
interface wes_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  wes_pkg::coord_t    pos_x;
  wes_pkg::coord_t    pos_y;
  logic [14:0]        win_width;
  logic [14:0]        win_height;
  logic               titled;
  logic [6:0]         border_width;
  logic               last;

  modport source (output valid, operation, pos_x, pos_y, win_width, win_height,
                  titled, border_width, last, input ready);
  modport sink (input valid, operation, pos_x, pos_y, win_width, win_height,
                titled, border_width, last, output ready);
endinterface

interface wes_out_if;
  logic            valid;
  logic            ready;
  wes_pkg::coord_t new_x;
  wes_pkg::coord_t new_y;

  modport source (output valid, new_x, new_y, input ready);
  modport sink (input valid, new_x, new_y, output ready);
endinterface

>>> hw/rtl/wes_front.sv
// Front end: input register and item classification, including the first
// screen edge snap of start items. Depends on wes_pkg and wes_if.
module wes_front (
  input  logic              clk,
  input  logic              rst,
  input  wes_pkg::cfg_t     cfg,
  wes_in_if.sink            items,
  output wes_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);

  logic              f_valid;
  wes_pkg::in_item_t f_item;

  logic signed [15:0] wd16, ht16, sw16, sh16, bw2, tofs16, y_lo;
  logic [7:0]         tofs;

  assign items.ready = !f_valid || job_ready;
  assign job_valid   = f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (items.ready) begin
      f_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      f_item.operation    <= items.operation;
      f_item.pos_x        <= items.pos_x;
      f_item.pos_y        <= items.pos_y;
      f_item.win_width    <= items.win_width;
      f_item.win_height   <= items.win_height;
      f_item.titled       <= items.titled;
      f_item.border_width <= items.border_width;
      f_item.last         <= items.last;
    end
  end

  always_comb begin
    tofs   = f_item.titled ? cfg.title_height : 8'd0;
    tofs16 = {8'd0, tofs};
    wd16   = {1'b0, f_item.win_width};
    ht16   = {1'b0, f_item.win_height};
    sw16   = {1'b0, cfg.screen_width};
    sh16   = {1'b0, cfg.screen_height};
    bw2    = {8'd0, f_item.border_width, 1'b0};
    y_lo   = f_item.pos_y - tofs16;

    job.nbr   = (f_item.operation == wes_pkg::OP_NEIGHBOR);
    job.last  = f_item.last;
    job.len_x = wd16;
    job.len_y = ht16 + tofs16;
    job.tofs  = tofs;
    if (job.nbr) begin
      job.px    = f_item.pos_x;
      job.py    = y_lo;
      job.aux_x = f_item.pos_x + wd16;
      job.aux_y = f_item.pos_y + ht16;  // title growth cancels on the bottom edge
    end else begin
      // near screen edges: left at 0, top at the title bar offset
      job.px    = wes_pkg::below_sd(f_item.pos_x, cfg.snap_distance) ? 16'sd0
                                                                     : f_item.pos_x;
      job.py    = wes_pkg::below_sd(y_lo, cfg.snap_distance) ? tofs16 : f_item.pos_y;
      job.aux_x = wd16 - sw16 + bw2;
      job.aux_y = ht16 - sh16 + bw2;
    end
  end

endmodule

>>> hw/rtl/wes_queue.sv
// Small FIFO that decouples the front end from the back end.
// Depends on wes_pkg for the job type.
module wes_queue #(
  parameter int DEPTH = wes_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wes_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output wes_pkg::job_t pop_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wes_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

>>> hw/rtl/wes_back.sv
// Back end: far screen edge snap, neighbor overlap test, best offset search and
// result output register. Depends on wes_pkg and wes_if.
module wes_back (
  input  logic          clk,
  input  logic          rst,
  input  wes_pkg::cfg_t cfg,
  input  wes_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  wes_out_if.source     results
);

  logic [7:0] sd;
  logic       back_en;

  // mover geometry (written by start items in stage A)
  wes_pkg::coord_t esx, esy, st, sh, mw;
  // best offsets (written in stage M)
  wes_pkg::coord_t bdx, bdy;

  // stage A
  logic            a_valid;
  wes_pkg::job_t   a_job;
  wes_pkg::coord_t x2, y2, st_next;
  logic            cond_x, cond_y;
  wes_pkg::coord_t [3:0] cx, cy;

  // stage B
  logic            b_valid, b_nbr, b_last, b_cond_x, b_cond_y;
  wes_pkg::coord_t [3:0] b_cx, b_cy;
  wes_pkg::coord_t b_esx, b_esy;
  wes_pkg::coord_t m4x, m4y;

  // stage M
  logic            m_valid, m_nbr, m_last, m_cond_x, m_cond_y;
  wes_pkg::coord_t m_dx, m_dy, m_esx, m_esy;
  wes_pkg::coord_t bdx_next, bdy_next;

  // stage C
  logic            c_valid;
  wes_pkg::coord_t c_esx, c_esy, c_dx, c_dy;
  wes_pkg::coord_t rx, ry;

  // output register
  logic            o_valid;
  wes_pkg::coord_t o_x, o_y;

  assign sd      = cfg.snap_distance;
  assign back_en = !c_valid || !o_valid || results.ready;
  assign pop     = back_en && head_valid;

  assign results.valid = o_valid;
  assign results.new_x = o_x;
  assign results.new_y = o_y;

  // stage A: far screen edge snap, overlap tests, candidate offsets
  always_comb begin
    x2 = wes_pkg::below_sd(a_job.px + a_job.aux_x, sd) ? -a_job.aux_x : a_job.px;
    y2 = wes_pkg::below_sd(a_job.py + a_job.aux_y, sd) ? -a_job.aux_y : a_job.py;
    st_next = y2 - $signed({8'd0, a_job.tofs});

    cond_x = wes_pkg::le_sd(a_job.py - sh - st, sd) &&
             wes_pkg::le_sd(st - a_job.len_y - a_job.py, sd);
    cond_y = wes_pkg::le_sd(a_job.px - mw - esx, sd) &&
             wes_pkg::le_sd(esx - a_job.len_x - a_job.px, sd);

    // order: far side, far side less length, near side less length, near side
    cx[0] = a_job.aux_x - esx;
    cx[1] = a_job.aux_x - esx - mw;
    cx[2] = a_job.px - esx - mw;
    cx[3] = a_job.px - esx;
    cy[0] = a_job.aux_y - st;
    cy[1] = a_job.aux_y - st - sh;
    cy[2] = a_job.py - st - sh;
    cy[3] = a_job.py - st;
  end

  // stage B: smallest of the four candidates, ties to the later one
  always_comb begin
    m4x = wes_pkg::lastmin(wes_pkg::lastmin(b_cx[0], b_cx[1]),
                           wes_pkg::lastmin(b_cx[2], b_cx[3]));
    m4y = wes_pkg::lastmin(wes_pkg::lastmin(b_cy[0], b_cy[1]),
                           wes_pkg::lastmin(b_cy[2], b_cy[3]));
  end

  // stage M: start items reset the running best; neighbor items merge into it
  always_comb begin
    if (!m_nbr) begin
      bdx_next = {8'd0, sd};
      bdy_next = {8'd0, sd};
    end else begin
      bdx_next = m_cond_x ? wes_pkg::lastmin(bdx, m_dx) : bdx;
      bdy_next = m_cond_y ? wes_pkg::lastmin(bdy, m_dy) : bdy;
    end
  end

  // stage C: apply offsets that are inside the snap distance
  always_comb begin
    rx = c_esx + (wes_pkg::below_sd(c_dx, sd) ? c_dx : 16'sd0);
    ry = c_esy + (wes_pkg::below_sd(c_dy, sd) ? c_dy : 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      m_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
      esx     <= '0;
      esy     <= '0;
      st      <= '0;
      sh      <= '0;
      mw      <= '0;
      bdx     <= {8'd0, wes_pkg::SNAP_DISTANCE_RESET};
      bdy     <= {8'd0, wes_pkg::SNAP_DISTANCE_RESET};
    end else begin
      if (back_en) begin
        a_valid <= head_valid;
        b_valid <= a_valid;
        m_valid <= b_valid;
        c_valid <= m_valid && m_last;
        if (a_valid && !a_job.nbr) begin
          esx <= x2;
          esy <= y2;
          st  <= st_next;
          sh  <= a_job.len_y;
          mw  <= a_job.len_x;
        end
        if (m_valid) begin
          bdx <= bdx_next;
          bdy <= bdy_next;
        end
      end
      if (!o_valid || results.ready) begin
        o_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      a_job    <= head;
      b_nbr    <= a_job.nbr;
      b_last   <= a_job.last;
      b_cond_x <= cond_x;
      b_cond_y <= cond_y;
      b_cx     <= cx;
      b_cy     <= cy;
      b_esx    <= a_job.nbr ? esx : x2;
      b_esy    <= a_job.nbr ? esy : y2;
      m_nbr    <= b_nbr;
      m_last   <= b_last;
      m_cond_x <= b_cond_x;
      m_cond_y <= b_cond_y;
      m_dx     <= m4x;
      m_dy     <= m4y;
      m_esx    <= b_esx;
      m_esy    <= b_esy;
      c_esx    <= m_esx;
      c_esy    <= m_esy;
      c_dx     <= bdx_next;
      c_dy     <= bdy_next;
    end
    if (!o_valid || results.ready) begin
      o_x <= rx;
      o_y <= ry;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    c_valid && o_valid && !results.ready |=> c_valid && $stable(c_esx) && $stable(c_dx))
    else $error("pending result lost while output stalled");
  a_start_resets_best: assert property (@(posedge clk) disable iff (rst)
    back_en && m_valid && !m_nbr |=>
      bdx == {8'd0, $past(sd)} && bdy == {8'd0, $past(sd)})
    else $error("start item did not reset best offsets");
  a_geometry_hold: assert property (@(posedge clk) disable iff (rst)
    !(back_en && a_valid && !a_job.nbr) |=> $stable(esx) && $stable(mw) && $stable(st))
    else $error("mover geometry changed without a start item");

endmodule

>>> hw/rtl/window_edge_snap.sv
// Top level of the window edge snap block: configuration registers, front end,
// decoupling queue and back end. Depends on wes_pkg, wes_if, wes_front,
// wes_queue and wes_back.
//
// Snaps a moving window to the screen edges and to neighbor windows. Send one
// start transfer (operation 0) with the mover's rectangle, border and title
// flag, then any number of neighbor transfers (operation 1); the transfer with
// last set produces one result transfer carrying new_x / new_y. A start with
// last set returns the screen-edge-snapped position alone. Neighbor selection
// (screen, desk) is up to the source. All coordinate math wraps at 16 bits.
// Throughput is one item per clock while results are taken and the queue has
// room: the back end keeps the running best offset per axis in a register that
// is read and updated once per item, and that update loop sets the rate. From
// input transfer to result an item passes the input register, the queue,
// four back end stages and the output register. The input side keeps taking
// items while a result waits on the output side until the queue (QUEUE_DEPTH
// entries) fills. Registers on the cfg port: 0 snap distance, 1 screen width,
// 2 screen height, 3 title height; write them only while no item is in flight.
module window_edge_snap #(
  parameter int QUEUE_DEPTH = wes_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wes_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]  cfg_data,
  wes_in_if.sink                          items,
  wes_out_if.source                       results
);

  wes_pkg::cfg_t cfg;

  // front -> queue
  wes_pkg::job_t job;
  logic          job_valid;
  logic          q_full;

  // queue -> back
  wes_pkg::job_t head;
  logic          q_empty;
  logic          pop;

  // Configuration registers; every index maps to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snap_distance <= wes_pkg::SNAP_DISTANCE_RESET;
      cfg.screen_width  <= wes_pkg::SCREEN_WIDTH_RESET;
      cfg.screen_height <= wes_pkg::SCREEN_HEIGHT_RESET;
      cfg.title_height  <= wes_pkg::TITLE_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (wes_pkg::cfg_index_t'(cfg_index))
        wes_pkg::CFG_SNAP_DISTANCE: cfg.snap_distance <= cfg_data[7:0];
        wes_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[14:0];
        wes_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[14:0];
        wes_pkg::CFG_TITLE_HEIGHT:  cfg.title_height  <= cfg_data[7:0];
        default:                    cfg.snap_distance <= cfg.snap_distance;
      endcase
    end
  end

  // Front: registers the input transfer, does the near screen edge snap of
  // start items and the title bar growth of every rectangle.
  wes_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .items     (items),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (!q_full)
  );

  // Queue: lets the input side run on while the output side is stalled.
  wes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid && !q_full),
    .push_data (job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  // Back: far screen edge snap, neighbor overlap and best offset tracking,
  // and the output register that holds a result until it is taken.
  wes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .results    (results)
  );

endmodule
